// ----- rtl/core/bbrt_pkg.sv -----
// Shared types, sizes and helpers for the block box range tagger.
package bbrt_pkg;

	localparam int MAX_BLOCK  = 4;
	localparam int MAX_BOXES  = 4;
	localparam int INDEX_BITS = 20;

	localparam int SLOT_COUNT = MAX_BLOCK * MAX_BOXES;
	localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int POS_BITS   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int BS_BITS    = $clog2(MAX_BLOCK + 1);
	localparam int NB_BITS    = $clog2(MAX_BOXES + 1);

	localparam int VAL_BITS   = 32;
	localparam int BIDX_BITS  = 20;
	localparam int COUNT_BITS = 21;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_COUNT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INVERT     = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef struct packed {
		logic                       cmd;
		logic [3:0]                 box_slot;
		logic signed [VAL_BITS-1:0] bound_low;
		logic signed [VAL_BITS-1:0] bound_high;
		logic signed [VAL_BITS-1:0] sample;
		logic                       restart;
	} in_t;

	typedef struct packed {
		logic [BIDX_BITS-1:0]  block_index;
		logic [COUNT_BITS-1:0] tagged_count;
	} out_t;

	typedef struct packed {
		logic [2:0] block_size;
		logic [2:0] box_count;
		logic       invert;
	} cfg_t;

	// data item in the compare stage, with the bounds read for each box
	typedef struct packed {
		logic                                 restart;
		logic                                 last;
		logic signed [VAL_BITS-1:0]           sample;
		logic [MAX_BOXES-1:0][VAL_BITS-1:0]   lows;
		logic [MAX_BOXES-1:0][VAL_BITS-1:0]   highs;
	} stage_t;

	function automatic logic [BS_BITS-1:0] eff_block(input logic [2:0] raw);
		logic [BS_BITS-1:0] r;
		if (raw == 3'd0) begin
			r = BS_BITS'(1);
		end else if (int'(raw) > MAX_BLOCK) begin
			r = BS_BITS'(MAX_BLOCK);
		end else begin
			r = BS_BITS'(raw);
		end
		return r;
	endfunction

	function automatic logic [NB_BITS-1:0] eff_boxes(input logic [2:0] raw);
		logic [NB_BITS-1:0] r;
		if (int'(raw) > MAX_BOXES) begin
			r = NB_BITS'(MAX_BOXES);
		end else begin
			r = NB_BITS'(raw);
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/bbrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bbrt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/bbrt_front.sv -----
// Input stage: bound loads, component position tracking, bound reads per box.
module bbrt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bbrt_pkg::in_t        in_data,
	input  bbrt_pkg::cfg_t       cfg,
	input  logic                 s1_free,
	output logic                 s1_valid,
	output bbrt_pkg::stage_t     s1
);

	logic                            accept;
	logic                            is_data;
	logic [bbrt_pkg::BS_BITS-1:0]    bs;
	logic [bbrt_pkg::POS_BITS-1:0]   pos_q;
	logic [bbrt_pkg::POS_BITS-1:0]   pos_use;
	logic [bbrt_pkg::POS_BITS-1:0]   pos_next;
	logic                            last;
	logic                            load_we;
	logic                            valid_s1;
	logic                            restart_s1;
	logic                            last_s1;
	logic signed [bbrt_pkg::VAL_BITS-1:0] sample_s1;

	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;
	assign is_data  = (in_data.cmd == bbrt_pkg::CMD_DATA);
	assign bs       = bbrt_pkg::eff_block(cfg.block_size);
	assign load_we  = accept && !is_data && (int'(in_data.box_slot) < bbrt_pkg::SLOT_COUNT);

	always_comb begin
		pos_use = in_data.restart ? '0 : pos_q;
		last    = (int'(pos_use) + 1) >= int'(bs);
		pos_next = last ? '0 : bbrt_pkg::POS_BITS'(int'(pos_use) + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept && is_data) begin
				pos_q <= pos_next;
			end
			if (s1_free) begin
				valid_s1 <= accept && is_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			restart_s1 <= in_data.restart;
			last_s1    <= last;
			sample_s1  <= in_data.sample;
		end
	end

	// one copy of the bound table per box so every box reads in the same cycle
	for (genvar k = 0; k < bbrt_pkg::MAX_BOXES; k++) begin : g_box
		logic [bbrt_pkg::SLOT_BITS-1:0]     raddr;
		logic [2*bbrt_pkg::VAL_BITS-1:0]    rdata;

		assign raddr = bbrt_pkg::SLOT_BITS'(k) * bbrt_pkg::SLOT_BITS'(bs)
			+ bbrt_pkg::SLOT_BITS'(pos_use);

		bbrt_ram #(
			.WIDTH(2 * bbrt_pkg::VAL_BITS),
			.DEPTH(bbrt_pkg::SLOT_COUNT)
		) u_bounds (
			.clk   (clk),
			.we    (load_we),
			.waddr (bbrt_pkg::SLOT_BITS'(in_data.box_slot)),
			.wdata ({in_data.bound_high, in_data.bound_low}),
			.re    (s1_free),
			.raddr (raddr),
			.rdata (rdata)
		);

		assign s1.lows[k]  = rdata[bbrt_pkg::VAL_BITS-1:0];
		assign s1.highs[k] = rdata[2*bbrt_pkg::VAL_BITS-1:bbrt_pkg::VAL_BITS];
	end

	assign s1_valid   = valid_s1;
	assign s1.restart = restart_s1;
	assign s1.last    = last_s1;
	assign s1.sample  = sample_s1;

endmodule

// ----- rtl/core/bbrt_eval.sv -----
// Compare stage: box membership, block tagging, counters and result register.
module bbrt_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbrt_pkg::cfg_t       cfg,
	input  logic                 s1_valid,
	input  bbrt_pkg::stage_t     s1,
	output logic                 s1_free,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bbrt_pkg::out_t       out_data
);

	logic [bbrt_pkg::NB_BITS-1:0]    nb;
	logic [bbrt_pkg::MAX_BOXES-1:0]  still_q;
	logic [bbrt_pkg::MAX_BOXES-1:0]  still_base;
	logic [bbrt_pkg::MAX_BOXES-1:0]  inside_now;
	logic [bbrt_pkg::MAX_BOXES-1:0]  box_used;
	logic [bbrt_pkg::INDEX_BITS-1:0] pos_q;
	logic [bbrt_pkg::INDEX_BITS-1:0] pos_base;
	logic [bbrt_pkg::COUNT_BITS-1:0] total_q;
	logic [bbrt_pkg::COUNT_BITS-1:0] total_base;
	logic [bbrt_pkg::COUNT_BITS-1:0] total_inc;
	logic                            block_hit;
	logic                            res;
	logic                            out_free;
	logic                            move;
	logic                            out_valid_q;
	bbrt_pkg::out_t                  out_q;

	assign nb = bbrt_pkg::eff_boxes(cfg.box_count);

	always_comb begin
		still_base = s1.restart ? '1 : still_q;
		pos_base   = s1.restart ? '0 : pos_q;
		total_base = s1.restart ? '0 : total_q;
		for (int k = 0; k < bbrt_pkg::MAX_BOXES; k++) begin
			box_used[k]   = k < int'(nb);
			inside_now[k] = still_base[k] && (!box_used[k]
				|| (($signed(s1.lows[k]) <= s1.sample)
				&& (s1.sample <= $signed(s1.highs[k]))));
		end
		block_hit = (|(inside_now & box_used)) ^ cfg.invert;
		res       = s1.last && block_hit;
		total_inc = (total_base == bbrt_pkg::COUNT_MAX) ? total_base
			: total_base + 1'b1;
	end

	assign out_free = !out_valid_q || !out_stall;
	// an item that yields no result moves on even while the output waits
	assign move     = s1_valid && (out_free || !res);
	assign s1_free  = !s1_valid || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q     <= '1;
			pos_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (move) begin
				if (s1.last) begin
					still_q <= '1;
					pos_q   <= pos_base + 1'b1;
					total_q <= block_hit ? total_inc : total_base;
				end else begin
					still_q <= inside_now;
					pos_q   <= pos_base;
					total_q <= total_base;
				end
			end
			if (move && res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move && res) begin
			out_q.block_index  <= bbrt_pkg::BIDX_BITS'(pos_base);
			out_q.tagged_count <= total_inc;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.tagged_count != '0))
		else $error("result carries a zero tagged count");

	a_block_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(move && s1.last) |=> (still_q == '1))
		else $error("box flags not reset after a block end");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(move && res && !s1.restart && (total_q != bbrt_pkg::COUNT_MAX))
		|=> (out_q.tagged_count == $past(total_q) + 1'b1))
		else $error("tagged count did not advance by one");

	a_no_result_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		(move && !s1.last) |=> !$rose(out_valid_q))
		else $error("result raised for a block that did not end");

endmodule

// ----- rtl/core/block_box_range_tagger_unit.sv -----
// Top level of the block box range tagger: config registers and the two stages.
//
// Items arrive on in_valid/in_stall/in_data. A load item (cmd 0) writes one
// bound pair into the box tables and yields nothing. A data item (cmd 1) is one
// component of a block; when it completes a block that is tagged, one result
// item leaves on out_valid/out_stall/out_data with the block index and the
// running tagged count. restart on a data item starts a new vector.
// Configuration (block_size, box_count, invert) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while no item is in
// flight, as the block does not enforce this. A result passes the bound read
// and stage registers, loaded when the item that ends the block is accepted,
// then the result register, loaded when that item leaves the compare stage.
// Throughput: one item per cycle while in_stall is low; each box has its
// own bound table copy, so all boxes read and compare in the same cycle.
// Stall: a held result stalls the compare stage only when that stage also
// holds a result; in_stall then rises in the same cycle.
// Reset clears the counters and config to block_size 1, box_count 0,
// invert 0; bound tables are not cleared and must be loaded before use.
module block_box_range_tagger_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bbrt_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bbrt_pkg::out_t                      out_data,
	input  logic                                cfg_we,
	input  logic [bbrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bbrt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	bbrt_pkg::cfg_t   cfg_q;
	bbrt_pkg::stage_t s1;
	logic             s1_valid;
	logic             s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size <= 3'd1;
			cfg_q.box_count  <= 3'd0;
			cfg_q.invert     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bbrt_pkg::REG_BLOCK_SIZE: cfg_q.block_size <= cfg_data;
				bbrt_pkg::REG_BOX_COUNT:  cfg_q.box_count  <= cfg_data;
				bbrt_pkg::REG_INVERT:     cfg_q.invert     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bbrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.s1_free  (s1_free),
		.s1_valid (s1_valid),
		.s1       (s1)
	);

	bbrt_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.s1_free   (s1_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
